// ===== design/sv32ptw_pkg.sv =====
// sv32ptw_pkg: beat types, walk state, register set and codes for the sv32 page table walker
// no dependencies; imported by sv32ptw_step, sv32_page_table_walker, sv32ptw_checker and tb
package sv32ptw_pkg;

  // input beat: translate request or returned page table entry
  typedef struct packed {
    logic        opcode;
    logic [31:0] virtual_address;
    logic [1:0]  access_kind;
    logic        user_mode;
    logic [31:0] entry_word;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] address;
    logic [2:0]  fault_reason;
  } out_beat_t;

  // walk state carried between beats
  typedef struct packed {
    logic        busy;
    logic        level;
    logic [31:0] held_address;
    logic [1:0]  held_access;
    logic        held_user;
  } walk_state_t;

  // configuration register set
  typedef struct packed {
    logic        translate_enable;
    logic [21:0] root_page_number;
    logic        make_exec_readable;
  } cfg_regs_t;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_ENTRY     = 1'b1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_FETCH = 2'd2;

  localparam logic [2:0] FLT_INVALID    = 3'd0;
  localparam logic [2:0] FLT_RESERVED   = 3'd1;
  localparam logic [2:0] FLT_NO_LEAF    = 3'd2;
  localparam logic [2:0] FLT_PERMISSION = 3'd3;
  localparam logic [2:0] FLT_USER       = 3'd4;
  localparam logic [2:0] FLT_MISALIGNED = 3'd5;
  localparam logic [2:0] FLT_NONE       = 3'd0;

  localparam logic [1:0] CFG_TRANSLATE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_ROOT_PAGE_NUMBER = 2'd1;
  localparam logic [1:0] CFG_MAKE_EXEC_READ   = 2'd2;

  localparam logic LEVEL_TOP  = 1'b1;
  localparam logic LEVEL_LEAF = 1'b0;

endpackage

// ===== design/sv32ptw_step.sv =====
// sv32ptw_step: combinational check-and-form step for one beat of the walk
// depends on sv32ptw_pkg
module sv32ptw_step (
  input  sv32ptw_pkg::in_beat_t    beat,
  input  sv32ptw_pkg::cfg_regs_t   cfg,
  input  sv32ptw_pkg::walk_state_t cur,
  output sv32ptw_pkg::walk_state_t nxt,
  output logic                     has_result,
  output sv32ptw_pkg::out_beat_t   result
);
  import sv32ptw_pkg::*;

  logic       pte_v, pte_r, pte_w, pte_x, pte_u;
  logic [9:0] vpn0;
  logic [9:0] req_vpn1;
  logic       allowed;

  assign pte_v    = beat.entry_word[0];
  assign pte_r    = beat.entry_word[1];
  assign pte_w    = beat.entry_word[2];
  assign pte_x    = beat.entry_word[3];
  assign pte_u    = beat.entry_word[4];
  assign vpn0     = cur.held_address[21:12];
  assign req_vpn1 = beat.virtual_address[31:22];

  always_comb begin
    case (cur.held_access)
      ACC_READ:  allowed = pte_r | (cfg.make_exec_readable & pte_x);
      ACC_WRITE: allowed = pte_w;
      ACC_FETCH: allowed = pte_x;
      default:   allowed = 1'b0;
    endcase
  end

  always_comb begin
    nxt        = cur;
    has_result = 1'b0;
    result     = '{result_kind: KIND_DONE, address: 32'd0, fault_reason: FLT_NONE};
    if (beat.opcode == OP_TRANSLATE) begin
      has_result = 1'b1;
      nxt.level  = LEVEL_TOP;
      if (!cfg.translate_enable) begin
        nxt.busy       = 1'b0;
        result.address = beat.virtual_address;
      end else begin
        nxt.busy           = 1'b1;
        nxt.held_address   = beat.virtual_address;
        nxt.held_access    = beat.access_kind;
        nxt.held_user      = beat.user_mode;
        result.result_kind = KIND_READ;
        // root page * 4096 + vpn1 * 4, kept to 32 bits
        result.address     = {cfg.root_page_number[19:0], req_vpn1, 2'b00};
      end
    end else if (cur.busy) begin
      has_result = 1'b1;
      // any fault ends the walk; overridden below for the pointer and done cases
      nxt.busy           = 1'b0;
      nxt.level          = LEVEL_TOP;
      result.result_kind = KIND_FAULT;
      if (!pte_v) begin
        result.fault_reason = FLT_INVALID;
      end else if (!pte_r && pte_w) begin
        result.fault_reason = FLT_RESERVED;
      end else if (!pte_r && !pte_x) begin
        if (cur.level == LEVEL_LEAF) begin
          result.fault_reason = FLT_NO_LEAF;
        end else begin
          nxt.busy           = 1'b1;
          nxt.level          = LEVEL_LEAF;
          result.result_kind = KIND_READ;
          result.address     = {beat.entry_word[29:10], vpn0, 2'b00};
        end
      end else if (!allowed) begin
        result.fault_reason = FLT_PERMISSION;
      end else if (cur.held_user && !pte_u) begin
        result.fault_reason = FLT_USER;
      end else if (cur.level == LEVEL_TOP && beat.entry_word[19:10] != 10'd0) begin
        result.fault_reason = FLT_MISALIGNED;
      end else begin
        result.result_kind = KIND_DONE;
        // superpage takes vpn0 from the virtual address
        result.address = {beat.entry_word[29:20],
                          (cur.level == LEVEL_TOP) ? vpn0 : beat.entry_word[19:10],
                          cur.held_address[11:0]};
      end
    end
  end

endmodule

// ===== design/sv32_page_table_walker.sv =====
// sv32_page_table_walker: top level, input register, walk state, result register, config
// depends on sv32ptw_pkg and sv32ptw_step
//
// Two-level Sv32 translation. A translate beat (opcode 0) either passes the
// address straight through as a done result (translation off) or starts a
// walk and returns a read-entry result with the level-one entry address. Each
// entry beat (opcode 1) returned by the memory side is checked and answered
// with the next entry address, the physical address or a numbered page fault;
// an entry beat while no walk is open is absorbed without a result. A new
// request drops any open walk. Timing: a beat is registered on input, checked
// by one short combinational step against the walk state, and its result
// lands in the output register as the beat advances out of the input register;
// one beat is taken every cycle while out_stall is low, set by the single
// input register draining into the single output register. The configuration
// port is always ready; writes are meant for idle periods.
module sv32_page_table_walker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sv32ptw_pkg::in_beat_t in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sv32ptw_pkg::out_beat_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import sv32ptw_pkg::*;

  // input register
  logic        in_full_r;
  in_beat_t    in_beat_r;
  // walk state and configuration
  walk_state_t walk_r, walk_nxt;
  cfg_regs_t   cfg_r;
  // result register
  logic        out_full_r;
  out_beat_t   out_beat_r;

  logic        step_has_result;
  out_beat_t   step_result;
  logic        advance;

  // the registered beat moves on once the result register is free or draining
  assign advance   = in_full_r && (!out_full_r || !out_stall);
  assign in_stall  = in_full_r && !advance;
  assign out_valid = out_full_r;
  assign out_data  = out_beat_r;
  assign cfg_ready = 1'b1;

  sv32ptw_step u_step (
    .beat       (in_beat_r),
    .cfg        (cfg_r),
    .cur        (walk_r),
    .nxt        (walk_nxt),
    .has_result (step_has_result),
    .result     (step_result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_beat_r <= in_data;
    end
  end

  // walk state follows the beat as it is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= '{busy: 1'b0, level: LEVEL_TOP, held_address: 32'd0,
                  held_access: 2'd0, held_user: 1'b0};
    end else if (advance) begin
      walk_r <= walk_nxt;
    end
  end

  // result register, filled only by beats that give a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (advance) begin
      out_full_r <= step_has_result;
    end else if (!out_stall) begin
      out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_has_result) begin
      out_beat_r <= step_result;
    end
  end

  // configuration registers; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{translate_enable: 1'b0, root_page_number: 22'd0, make_exec_readable: 1'b0};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRANSLATE_ENABLE: cfg_r.translate_enable   <= cfg_data[0];
        CFG_ROOT_PAGE_NUMBER: cfg_r.root_page_number   <= cfg_data[21:0];
        CFG_MAKE_EXEC_READ:   cfg_r.make_exec_readable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== dv/sv32ptw_checker.sv =====
// sv32ptw_checker: watches the walker's input, result and register ports, predicts results
// depends on sv32ptw_pkg; instantiated beside the walker by tb
`timescale 1ns / 1ps

module sv32ptw_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  sv32ptw_pkg::in_beat_t  in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  sv32ptw_pkg::out_beat_t out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  output int                     fail_count,
  output int                     pending_results
);
  import sv32ptw_pkg::*;

  // shadow registers
  logic        xlate_on;
  logic [21:0] root_ppn;
  logic        mxr;

  // shadow walk state
  logic        walk_open;
  logic        walk_lvl;
  logic [31:0] walk_va;
  logic [1:0]  walk_acc;
  logic        walk_usr;

  out_beat_t   expected_results[$];

  function automatic out_beat_t close_walk(logic [1:0] kind, logic [31:0] addr,
                                           logic [2:0] reason);
    walk_open = 1'b0;
    walk_lvl  = LEVEL_TOP;
    return '{kind, addr, reason};
  endfunction

  // one beat through the walk; returns 1 when a result is due
  function automatic bit walk_step(input in_beat_t b, output out_beat_t res);
    logic [31:0] pte;
    logic        v, rd, wr, ex, us, ok;
    logic [9:0]  low_ppn;
    pte = b.entry_word;
    res = '0;
    if (b.opcode == OP_TRANSLATE) begin
      if (!xlate_on) begin
        res = close_walk(KIND_DONE, b.virtual_address, FLT_NONE);
        return 1'b1;
      end
      walk_va   = b.virtual_address;
      walk_acc  = b.access_kind;
      walk_usr  = b.user_mode;
      walk_open = 1'b1;
      walk_lvl  = LEVEL_TOP;
      res = '{KIND_READ,
              {root_ppn[19:0], 12'h000} + {20'h0, b.virtual_address[31:22], 2'b00},
              FLT_NONE};
      return 1'b1;
    end
    if (!walk_open) return 1'b0;
    v  = pte[0];
    rd = pte[1];
    wr = pte[2];
    ex = pte[3];
    us = pte[4];
    if (!v) begin
      res = close_walk(KIND_FAULT, 32'h0, FLT_INVALID);
      return 1'b1;
    end
    if (!rd && wr) begin
      res = close_walk(KIND_FAULT, 32'h0, FLT_RESERVED);
      return 1'b1;
    end
    if (!rd && !ex) begin
      if (walk_lvl == LEVEL_LEAF) begin
        res = close_walk(KIND_FAULT, 32'h0, FLT_NO_LEAF);
        return 1'b1;
      end
      walk_lvl = LEVEL_LEAF;
      res = '{KIND_READ, {pte[29:10], 12'h000} + {20'h0, walk_va[21:12], 2'b00}, FLT_NONE};
      return 1'b1;
    end
    case (walk_acc)
      ACC_READ:  ok = rd || (mxr && ex);
      ACC_WRITE: ok = wr;
      ACC_FETCH: ok = ex;
      default:   ok = 1'b0;
    endcase
    if (!ok) begin
      res = close_walk(KIND_FAULT, 32'h0, FLT_PERMISSION);
      return 1'b1;
    end
    if (walk_usr && !us) begin
      res = close_walk(KIND_FAULT, 32'h0, FLT_USER);
      return 1'b1;
    end
    if (walk_lvl == LEVEL_TOP && pte[19:10] != 10'h0) begin
      res = close_walk(KIND_FAULT, 32'h0, FLT_MISALIGNED);
      return 1'b1;
    end
    low_ppn = (walk_lvl == LEVEL_TOP) ? walk_va[21:12] : pte[19:10];
    // physical address keeps only the low ten bits of the top page number
    res = close_walk(KIND_DONE, {pte[29:20], low_ppn, walk_va[11:0]}, FLT_NONE);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t want, pred;
    if (!rst_n) begin
      fail_count = 0;
      xlate_on  = 1'b0;
      root_ppn  = '0;
      mxr       = 1'b0;
      walk_open = 1'b0;
      walk_lvl  = LEVEL_TOP;
      walk_va   = '0;
      walk_acc  = '0;
      walk_usr  = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result beat with nothing expected: kind %0d address %h reason %0d",
                 out_data.result_kind, out_data.address, out_data.fault_reason);
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_kind !== want.result_kind) begin
            fail_count++;
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   out_data.result_kind);
          end
          if (out_data.address !== want.address) begin
            fail_count++;
            $error("address: expected %h, got %h", want.address, out_data.address);
          end
          if (out_data.fault_reason !== want.fault_reason) begin
            fail_count++;
            $error("fault_reason: expected %0d, got %0d", want.fault_reason,
                   out_data.fault_reason);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TRANSLATE_ENABLE: xlate_on = cfg_data[0];
          CFG_ROOT_PAGE_NUMBER: root_ppn = cfg_data[21:0];
          CFG_MAKE_EXEC_READ:   mxr      = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (walk_step(in_data, pred)) expected_results.push_back(pred);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== dv/tb.sv =====
// tb: stimulus and verdict for the sv32 page table walker
// depends on sv32ptw_pkg, sv32_page_table_walker and sv32ptw_checker
`timescale 1ns / 1ps

module tb;
  import sv32ptw_pkg::*;

  // far above the slowest correct run
  localparam int CYCLE_LIMIT = 400000;

  // page table entry flag bits
  localparam logic [31:0] PTE_V = 32'h0000_0001;
  localparam logic [31:0] PTE_R = 32'h0000_0002;
  localparam logic [31:0] PTE_W = 32'h0000_0004;
  localparam logic [31:0] PTE_X = 32'h0000_0008;
  localparam logic [31:0] PTE_U = 32'h0000_0010;

  // access kind with no permission at all
  localparam logic [1:0] ACC_NONE = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  int fail_count;
  int pending_results;
  int cycle_count = 0;
  int gap_pct     = 0;   // chance in a hundred that the sender idles a cycle
  int hold_pct    = 0;   // chance in a hundred that the receiver stalls a cycle

  always #5 clk = ~clk;

  // receiver stalls are drawn fresh every cycle
  always @(negedge clk) out_stall <= ($urandom_range(99) < hold_pct);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  sv32_page_table_walker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sv32ptw_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // translate request; the entry field is junk but still toggles
  function automatic in_beat_t req_beat(logic [31:0] va, logic [1:0] acc, logic usr);
    in_beat_t b;
    b.opcode          = OP_TRANSLATE;
    b.virtual_address = va;
    b.access_kind     = acc;
    b.user_mode       = usr;
    b.entry_word      = $urandom;
    return b;
  endfunction

  // returned entry; request fields are junk
  function automatic in_beat_t pte_beat(logic [31:0] word);
    in_beat_t b;
    b.opcode          = OP_ENTRY;
    b.virtual_address = $urandom;
    b.access_kind     = 2'($urandom_range(3));
    b.user_mode       = 1'($urandom_range(1));
    b.entry_word      = word;
    return b;
  endfunction

  // mostly legal access kinds, now and then the one with no permission
  function automatic logic [1:0] pick_access();
    if ($urandom_range(9) == 0) return ACC_NONE;
    return 2'($urandom_range(2));
  endfunction

  // pointer to the next level: valid with no r, w or x
  function automatic logic [31:0] pointer_word();
    logic [31:0] e;
    e = $urandom;
    e = (e & ~(PTE_R | PTE_W | PTE_X)) | PTE_V;
    return e;
  endfunction

  // leaf with a legal permission mix; top-level leaves are mostly aligned
  function automatic logic [31:0] leaf_word(bit top);
    logic [31:0] e;
    e = ($urandom & ~(PTE_R | PTE_W | PTE_X)) | PTE_V;
    case ($urandom_range(4))
      0:       e |= PTE_R;
      1:       e |= PTE_R | PTE_W;
      2:       e |= PTE_X;
      3:       e |= PTE_R | PTE_X;
      default: e |= PTE_R | PTE_W | PTE_X;
    endcase
    if (top && $urandom_range(9) < 7) e[19:10] = 10'h0;
    return e;
  endfunction

  // present one beat at the falling edge and hold it until taken
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending, let every expected result drain, then idle on
  // in case the last beat was an entry the walker swallows
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all three registers, with junk in the unused upper data bits
  task automatic set_walk_cfg(input logic en, input logic [21:0] root, input logic exec_rd);
    write_reg(CFG_TRANSLATE_ENABLE, ($urandom & ~32'h1) | 32'(en));
    write_reg(CFG_ROOT_PAGE_NUMBER, ($urandom & 32'hffc0_0000) | 32'(root));
    write_reg(CFG_MAKE_EXEC_READ, ($urandom & ~32'h1) | 32'(exec_rd));
  endtask

  // one walk with random content: request, then one or two entries; a small
  // share is a stray entry or a request left open for the next one to drop
  task automatic random_walk(input bit xlate, inout int sent);
    int pick;
    logic [31:0] word;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_beat(pte_beat($urandom));
      return;
    end
    send_beat(req_beat($urandom, pick_access(), 1'($urandom_range(1))));
    sent++;
    if (pick < 14) return;
    pick = $urandom_range(99);
    if (pick < 40)      word = pointer_word();
    else if (pick < 85) word = leaf_word(1'b1);
    else                word = $urandom;
    send_beat(pte_beat(word));
    if (xlate) sent++;
    // a second level only follows a pointer
    if (!(word[0] && (word & (PTE_R | PTE_W | PTE_X)) == 32'h0)) return;
    pick = $urandom_range(99);
    if (pick < 80)      word = leaf_word(1'b0);
    else if (pick < 90) word = pointer_word();
    else                word = $urandom;
    send_beat(pte_beat(word));
    if (xlate) sent++;
  endtask

  initial begin
    int sent;
    int target;
    logic xlate;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: bare mode straight after reset, address extremes pass through
    gap_pct  = 6;
    hold_pct = 78;
    send_beat(req_beat(32'h0000_0000, ACC_READ, 1'b0));
    send_beat(req_beat(32'hffff_ffff, ACC_FETCH, 1'b1));
    // entry with no walk open is swallowed
    send_beat(pte_beat(32'hffff_ffff));
    settle();

    // directed: translation on, root at the top of its range
    set_walk_cfg(1'b1, 22'h3f_ffff, 1'b0);
    // invalid entry at the top level
    send_beat(req_beat(32'hffff_ffff, ACC_READ, 1'b1));
    send_beat(pte_beat(32'hffff_fffe));
    // write-only entry is reserved
    send_beat(req_beat(32'h8000_0000, ACC_WRITE, 1'b0));
    send_beat(pte_beat(32'hffff_fc00 | PTE_V | PTE_W));
    // pointer at both levels: no leaf found
    send_beat(req_beat(32'h0040_1000, ACC_READ, 1'b0));
    send_beat(pte_beat(32'hffff_fc00 | PTE_V));
    send_beat(pte_beat(PTE_V));
    // execute-only page read with mxr off
    send_beat(req_beat(32'h1234_5678, ACC_READ, 1'b1));
    send_beat(pte_beat(PTE_V | PTE_X | PTE_U));
    // write to a read-only page
    send_beat(req_beat(32'h1234_5678, ACC_WRITE, 1'b1));
    send_beat(pte_beat(PTE_V | PTE_R | PTE_U));
    // access kind with no permission, even on a full-permission page
    send_beat(req_beat(32'h0000_0fff, ACC_NONE, 1'b0));
    send_beat(pte_beat(PTE_V | PTE_R | PTE_W | PTE_X | PTE_U));
    // user access to a supervisor page
    send_beat(req_beat(32'hfedc_ba98, ACC_READ, 1'b1));
    send_beat(pte_beat(PTE_V | PTE_R | PTE_W | PTE_X));
    // superpage with a non-zero low page number
    send_beat(req_beat(32'h0000_0000, ACC_READ, 1'b0));
    send_beat(pte_beat(32'h0000_0400 | PTE_V | PTE_R));
    // aligned superpage, supervisor fetch from a supervisor page
    send_beat(req_beat(32'hffff_ffff, ACC_FETCH, 1'b0));
    send_beat(pte_beat(32'hfff0_03ef));
    // full two-level walk ending in a 4k page
    send_beat(req_beat(32'hffff_ffff, ACC_WRITE, 1'b1));
    send_beat(pte_beat(32'hffff_fc00 | PTE_V));
    send_beat(pte_beat(32'hffff_ffff));
    settle();

    // mxr on, root at zero: execute-only page becomes readable
    set_walk_cfg(1'b1, 22'h0, 1'b1);
    send_beat(req_beat(32'h0000_0000, ACC_READ, 1'b0));
    send_beat(pte_beat(32'h0000_0000 | PTE_V | PTE_X));

    // random phases, each opened once the walker has drained
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          set_walk_cfg(1'b1, 22'($urandom_range(22'h3f_ffff)), 1'b0);
          gap_pct  = 6;
          hold_pct = 78;
          target   = 700;
        end
        1: begin
          set_walk_cfg(1'b1, 22'h0, 1'b1);
          gap_pct  = 78;
          hold_pct = 6;
          target   = 700;
        end
        2: begin
          // short bare stretch, entries are ignored here
          set_walk_cfg(1'b0, 22'($urandom_range(22'h3f_ffff)), 1'($urandom_range(1)));
          gap_pct  = 0;
          hold_pct = 0;
          target   = 100;
        end
        default: begin
          set_walk_cfg(1'b1, 22'h3f_ffff, 1'($urandom_range(1)));
          gap_pct  = 0;
          hold_pct = 0;
          target   = 500;
        end
      endcase
      xlate = (p != 2);
      sent  = 0;
      while (sent < target) random_walk(xlate, sent);
    end

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sv32ptw_pkg.sv
design/sv32ptw_step.sv
design/sv32_page_table_walker.sv
dv/sv32ptw_checker.sv
dv/tb.sv
